// ----- hdl/mts_pkg.sv -----
// Shared types, codes and constants of the min-tracking stack.
`timescale 1ns / 1ps
`default_nettype none
package mts_pkg;

    localparam int DEPTH_DEFAULT = 64;
    localparam int WORD_W        = 32;
    localparam int STATUS_W      = 2;

    typedef logic signed [WORD_W-1:0] t_word;
    typedef logic [STATUS_W-1:0]      t_status;

    localparam t_word NONE_WORD = '1;

    localparam logic FN_PUSH = 1'b0;
    localparam logic FN_POP  = 1'b1;

    localparam t_status ST_OK        = 2'd0;
    localparam t_status ST_POP_EMPTY = 2'd1;
    localparam t_status ST_PUSH_FULL = 2'd2;

    // Shift command broadcast to every cell of a row.
    typedef struct packed {
        logic push;
        logic pop;
    } t_shift;

endpackage
`default_nettype wire

// ----- hdl/mts_ifs.sv -----
// Request and result channel interfaces of the min-tracking stack.
`timescale 1ns / 1ps
`default_nettype none
interface mts_req_if;
    logic          valid;
    logic          ready;
    logic          func;
    mts_pkg::t_word value;

    modport source (output valid, func, value, input ready);
    modport sink   (input valid, func, value, output ready);
endinterface

interface mts_rsp_if;
    logic            valid;
    logic            ready;
    mts_pkg::t_word   top_value;
    mts_pkg::t_word   min_value;
    mts_pkg::t_word   popped_value;
    logic            is_empty;
    mts_pkg::t_status status;

    modport source (output valid, top_value, min_value, popped_value, is_empty, status,
                    input ready);
    modport sink   (input valid, top_value, min_value, popped_value, is_empty, status,
                    output ready);
endinterface
`default_nettype wire

// ----- hdl/mts_cell.sv -----
// One stack cell: holds a word and takes a neighbor's word on a shift.
`timescale 1ns / 1ps
`default_nettype none
module mts_cell (
    input  wire logic            i_clk,
    input  wire mts_pkg::t_shift i_shift,
    input  wire mts_pkg::t_word  i_above,
    input  wire mts_pkg::t_word  i_below,
    output mts_pkg::t_word       o_word
);

    mts_pkg::t_word r_word;
    mts_pkg::t_word n_word;

    always_comb begin
        n_word = r_word;
        if (i_shift.push) begin
            n_word = i_above;
        end else if (i_shift.pop) begin
            n_word = i_below;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word = r_word;

endmodule
`default_nettype wire

// ----- hdl/mts_chain.sv -----
// Row of stack cells; cell 0 is the top, a push shifts down, a pop shifts up.
`timescale 1ns / 1ps
`default_nettype none
module mts_chain #(
    parameter int DEPTH = mts_pkg::DEPTH_DEFAULT
) (
    input  wire logic            i_clk,
    input  wire mts_pkg::t_shift i_shift,
    input  wire mts_pkg::t_word  i_data,
    output mts_pkg::t_word       o_tap0,
    output mts_pkg::t_word       o_tap1
);

    mts_pkg::t_word w_cell [DEPTH];

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        mts_pkg::t_word w_above;
        mts_pkg::t_word w_below;

        if (g == 0) begin : g_head
            assign w_above = i_data;
        end else begin : g_body
            assign w_above = w_cell[g-1];
        end

        if (g == DEPTH - 1) begin : g_tail
            assign w_below = '0;
        end else begin : g_inner
            assign w_below = w_cell[g+1];
        end

        mts_cell u_cell (
            .i_clk   (i_clk),
            .i_shift (i_shift),
            .i_above (w_above),
            .i_below (w_below),
            .o_word  (w_cell[g])
        );
    end

    assign o_tap0 = w_cell[0];
    assign o_tap1 = w_cell[1];

endmodule
`default_nettype wire

// ----- hdl/min_tracking_stack_unit.sv -----
// Top level of the min-tracking stack: control, two cell rows, result register.
`timescale 1ns / 1ps
`default_nettype none
// A stack of signed 32-bit words that also reports its running minimum. Each
// request is a push (func 0) or a pop (func 1) and yields exactly one result:
// the top and minimum after the operation (-1 when empty), the popped word
// (-1 on a push or a refused pop), an empty flag, and a status (ok, pop on
// empty refused, push on full refused). Storage is two rows of DEPTH cells,
// one for values and one for minima, with the top of each row in its first
// cell; every cell of a row shifts in the same cycle, so an operation sees
// the tops and the entry below them directly. One request is taken per
// clock: the result is loaded into the output register on acceptance,
// and a new request is taken whenever that register is empty or being
// drained in the same cycle. No clearing pass follows reset; the stack is
// empty and ready right away.
module min_tracking_stack_unit #(
    parameter int DEPTH = mts_pkg::DEPTH_DEFAULT
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    mts_req_if.sink   i_req,
    mts_rsp_if.source o_rsp
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    // Fill counts of the two rows.
    logic [CNT_W-1:0] r_val_cnt;
    logic [CNT_W-1:0] n_val_cnt;
    logic [CNT_W-1:0] r_min_cnt;
    logic [CNT_W-1:0] n_min_cnt;

    // Output register.
    logic             r_out_valid;
    mts_pkg::t_word   r_top;
    mts_pkg::t_word   r_min;
    mts_pkg::t_word   r_popped;
    logic             r_empty;
    mts_pkg::t_status r_status;

    mts_pkg::t_word   n_top;
    mts_pkg::t_word   n_min;
    mts_pkg::t_word   n_popped;
    logic             n_empty;
    mts_pkg::t_status n_status;

    mts_pkg::t_shift  w_val_shift;
    mts_pkg::t_shift  w_min_shift;
    mts_pkg::t_word   w_val0;
    mts_pkg::t_word   w_val1;
    mts_pkg::t_word   w_min0;
    mts_pkg::t_word   w_min1;

    logic w_accept;
    logic w_full;
    logic w_none;

    // Take a request whenever the result register is free or draining; hold off in reset.
    assign i_req.ready = i_rst_n && (!r_out_valid || o_rsp.ready);
    assign w_accept    = i_req.valid && i_req.ready;

    assign w_full = (r_val_cnt == CNT_W'(DEPTH));
    assign w_none = (r_val_cnt == '0);

    always_comb begin
        w_val_shift = '0;
        w_min_shift = '0;
        n_val_cnt   = r_val_cnt;
        n_min_cnt   = r_min_cnt;
        n_popped    = mts_pkg::NONE_WORD;
        n_status    = mts_pkg::ST_OK;

        if (w_accept) begin
            if (i_req.func == mts_pkg::FN_PUSH) begin
                if (w_full) begin
                    n_status = mts_pkg::ST_PUSH_FULL;
                end else begin
                    w_val_shift.push = 1'b1;
                    n_val_cnt        = r_val_cnt + 1'b1;
                    // Record a new minimum on ties too, so pops stay paired.
                    if (r_min_cnt == '0 || i_req.value <= w_min0) begin
                        w_min_shift.push = 1'b1;
                        n_min_cnt        = r_min_cnt + 1'b1;
                    end
                end
            end else begin
                if (w_none) begin
                    n_status = mts_pkg::ST_POP_EMPTY;
                end else begin
                    w_val_shift.pop = 1'b1;
                    n_val_cnt       = r_val_cnt - 1'b1;
                    n_popped        = w_val0;
                    if (r_min_cnt != '0 && w_min0 == w_val0) begin
                        w_min_shift.pop = 1'b1;
                        n_min_cnt       = r_min_cnt - 1'b1;
                    end
                end
            end
        end

        // Describe the stack after the operation from the pre-shift taps.
        n_empty = (n_val_cnt == '0);
        if (w_val_shift.push) begin
            n_top = i_req.value;
        end else if (w_val_shift.pop) begin
            n_top = w_val1;
        end else begin
            n_top = w_val0;
        end
        if (w_min_shift.push) begin
            n_min = i_req.value;
        end else if (w_min_shift.pop) begin
            n_min = w_min1;
        end else begin
            n_min = w_min0;
        end
        if (n_empty) begin
            n_top = mts_pkg::NONE_WORD;
        end
        if (n_empty || n_min_cnt == '0) begin
            n_min = mts_pkg::NONE_WORD;
        end
    end

    mts_chain #(
        .DEPTH (DEPTH)
    ) u_val_chain (
        .i_clk   (i_clk),
        .i_shift (w_val_shift),
        .i_data  (i_req.value),
        .o_tap0  (w_val0),
        .o_tap1  (w_val1)
    );

    mts_chain #(
        .DEPTH (DEPTH)
    ) u_min_chain (
        .i_clk   (i_clk),
        .i_shift (w_min_shift),
        .i_data  (i_req.value),
        .o_tap0  (w_min0),
        .o_tap1  (w_min1)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_val_cnt   <= '0;
            r_min_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_val_cnt <= n_val_cnt;
            r_min_cnt <= n_min_cnt;
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Hold the result until it is taken; load only on an accepted request.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_top    <= n_top;
            r_min    <= n_min;
            r_popped <= n_popped;
            r_empty  <= n_empty;
            r_status <= n_status;
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.top_value    = r_top;
    assign o_rsp.min_value    = r_min;
    assign o_rsp.popped_value = r_popped;
    assign o_rsp.is_empty     = r_empty;
    assign o_rsp.status       = r_status;

`ifndef SYNTHESIS
    a_min_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_min_cnt <= r_val_cnt)
        else $error("minima count exceeds value count");

    a_min_cnt_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_val_cnt == '0) == (r_min_cnt == '0))
        else $error("minima row and value row disagree on emptiness");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_req.func == mts_pkg::FN_PUSH && !w_full)
        |=> (r_val_cnt == $past(r_val_cnt) + 1'b1))
        else $error("accepted push did not grow the stack");

    a_refused_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status == mts_pkg::ST_POP_EMPTY)
        |-> (r_empty && r_top == mts_pkg::NONE_WORD))
        else $error("refused pop reported a non-empty stack");
`endif

endmodule
`default_nettype wire
